### rtl/sdc_pkg.sv
// ----------------------------------------------------------------------------
// sdc_pkg: shared types and constants of the sequence dedup cache
// Operation and status codes, default sizes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sdc_pkg;

   localparam int SDC_MAX_ENTRIES  = 256;
   localparam int SDC_MAX_CHILDREN = 256;

   localparam int DESC_W   = 16;
   localparam int ID_W     = 16;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_STORE  = 2'd1,
      OP_SEARCH = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND     = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_STORED    = 3'd2,
      ST_FULL      = 3'd3,
      ST_TOO_LONG  = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       clear;
      logic       exec;
      logic       commit;
      logic       srch_init;
      logic       entry_step;
      logic       elem_step;
      logic       result_load;
      status_type result_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            last;
      logic            too_long;
      logic            full;
      logic            entry_end;
      logic            len_match;
      logic            elem_match;
      logic            elem_end;
      logic            rsp_busy;
   } dp_status_type;

endpackage

### rtl/sdc_datapath.sv
// ----------------------------------------------------------------------------
// sdc_datapath: storage, counters and result register
// Holds the entry tables, the query buffer, the position and entry counters
// and the output register, and carries out the controller's commands.
// ----------------------------------------------------------------------------
module sdc_datapath
   import sdc_pkg::*;
#(
   parameter int MAX_ENTRIES  = SDC_MAX_ENTRIES,
   parameter int MAX_CHILDREN = SDC_MAX_CHILDREN
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output dp_status_type       sts,
   input  logic [2*DESC_W-1:0] req_tdata,
   input  logic [OP_W-1:0]     req_tuser,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [ID_W-1:0]     rsp_tdata,
   output logic [STATUS_W-1:0] rsp_tuser
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int NW = $clog2(MAX_ENTRIES + 1);
   localparam int CW = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
   localparam int PW = $clog2(MAX_CHILDREN + 1);
   localparam int ID_DEPTH = 2 ** IW;
   localparam int EL_DEPTH = 2 ** (IW + CW);
   localparam int Q_DEPTH  = 2 ** CW;
   localparam logic [NW-1:0] COUNT_MAX = NW'(MAX_ENTRIES);
   localparam logic [PW-1:0] POS_MAX   = PW'(MAX_CHILDREN);

   logic [ID_W-1:0]   id_mem   [ID_DEPTH];
   logic [PW-1:0]     len_mem  [ID_DEPTH];
   logic [DESC_W-1:0] elem_mem [EL_DEPTH];
   logic [DESC_W-1:0] q_mem    [Q_DEPTH];

   logic [OP_W-1:0]     op_ff;
   logic [DESC_W-1:0]   desc_ff;
   logic [ID_W-1:0]     id_ff;
   logic                last_ff;
   logic [NW-1:0]       count_ff;
   logic [PW-1:0]       pos_ff;
   logic                flag_ff;
   logic [PW-1:0]       qlen_ff;
   logic [NW-1:0]       entry_ff;
   logic [PW-1:0]       elem_ff;
   logic [ID_W-1:0]     id_rd_ff;
   logic [PW-1:0]       len_rd_ff;
   logic [DESC_W-1:0]   elem_rd_ff;
   logic [DESC_W-1:0]   q_rd_ff;
   logic                rsp_valid_ff;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic          too_long;
   logic          full;
   logic [PW-1:0] pos_next;
   logic [IW-1:0] wr_entry;
   logic [IW-1:0] rd_entry;

   assign too_long = flag_ff || (pos_ff >= POS_MAX);
   assign full     = (count_ff >= COUNT_MAX);
   assign pos_next = pos_ff + PW'(1);
   assign wr_entry = count_ff[IW-1:0];
   assign rd_entry = entry_ff[IW-1:0];

   // Item capture, and the sequence length latched at an end item.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_tuser;
         desc_ff <= req_tdata[DESC_W-1:0];
         id_ff   <= req_tdata[2*DESC_W-1:DESC_W];
         last_ff <= req_tlast;
      end
      if (cmd.exec && last_ff) begin
         qlen_ff <= pos_next;
      end
   end

   // Counters and the too-long flag.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         pos_ff   <= '0;
         flag_ff  <= 1'b0;
      end else begin
         if (cmd.exec) begin
            if (last_ff) begin
               pos_ff  <= '0;
               flag_ff <= 1'b0;
            end else if (too_long) begin
               flag_ff <= 1'b1;
            end else begin
               pos_ff <= pos_next;
            end
         end
         if (cmd.commit) begin
            count_ff <= count_ff + NW'(1);
         end
      end
   end

   // Search walk counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         elem_ff  <= '0;
      end else if (cmd.srch_init) begin
         entry_ff <= '0;
         elem_ff  <= '0;
      end else if (cmd.entry_step) begin
         entry_ff <= entry_ff + NW'(1);
         elem_ff  <= '0;
      end else if (cmd.elem_step) begin
         elem_ff <= elem_ff + PW'(1);
      end
   end

   // Memory writes.
   always_ff @(posedge clock) begin
      if (cmd.exec && !too_long) begin
         if (op_type'(op_ff) == OP_STORE && !full) begin
            elem_mem[{wr_entry, pos_ff[CW-1:0]}] <= desc_ff;
         end
         if (op_type'(op_ff) == OP_SEARCH) begin
            q_mem[pos_ff[CW-1:0]] <= desc_ff;
         end
      end
      if (cmd.commit) begin
         id_mem[wr_entry]  <= id_ff;
         len_mem[wr_entry] <= pos_next;
      end
   end

   // Registered reads, addressed by the walk counters every cycle.
   always_ff @(posedge clock) begin
      id_rd_ff   <= id_mem[rd_entry];
      len_rd_ff  <= len_mem[rd_entry];
      elem_rd_ff <= elem_mem[{rd_entry, elem_ff[CW-1:0]}];
      q_rd_ff    <= q_mem[elem_ff[CW-1:0]];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_status_ff <= cmd.result_status;
         rsp_id_ff     <= (cmd.result_status == ST_FOUND) ? id_rd_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      sts.op         = op_ff;
      sts.last       = last_ff;
      sts.too_long   = too_long;
      sts.full       = full;
      sts.entry_end  = (entry_ff == count_ff);
      sts.len_match  = (len_rd_ff == qlen_ff);
      sts.elem_match = (elem_rd_ff == q_rd_ff);
      sts.elem_end   = ((elem_ff + PW'(1)) == qlen_ff);
      sts.rsp_busy   = rsp_valid_ff;
   end

endmodule

### rtl/sdc_controller.sv
// ----------------------------------------------------------------------------
// sdc_controller: sequencing of the dedup cache
// Accepts an item, executes it, and for a search walks the stored entries
// one length check and one element compare at a time.
// ----------------------------------------------------------------------------
module sdc_controller
   import sdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type sts,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      IDLE,
      EXEC,
      LEN_RD,
      LEN_CHK,
      EL_RD,
      EL_CHK,
      RESULT
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   status_type result_ff;
   status_type result_in;

   always_comb begin
      state_in          = state_ff;
      result_in         = result_ff;
      cmd               = '0;
      cmd.result_status = result_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = EXEC;
            end
         end
         EXEC: begin
            unique case (sts.op) inside
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = IDLE;
               end
               OP_STORE, OP_SEARCH: begin
                  cmd.exec = 1'b1;
                  if (!sts.last) begin
                     state_in = IDLE;
                  end else if (sts.too_long) begin
                     result_in = ST_TOO_LONG;
                     state_in  = RESULT;
                  end else if (sts.op == OP_STORE) begin
                     if (sts.full) begin
                        result_in = ST_FULL;
                     end else begin
                        cmd.commit = 1'b1;
                        result_in  = ST_STORED;
                     end
                     state_in = RESULT;
                  end else begin
                     cmd.srch_init = 1'b1;
                     state_in      = LEN_RD;
                  end
               end
               default: begin
                  state_in = IDLE;
               end
            endcase
         end
         LEN_RD: begin
            if (sts.entry_end) begin
               result_in = ST_NOT_FOUND;
               state_in  = RESULT;
            end else begin
               state_in = LEN_CHK;
            end
         end
         LEN_CHK: begin
            if (sts.len_match) begin
               state_in = EL_CHK;
            end else begin
               cmd.entry_step = 1'b1;
               state_in       = LEN_RD;
            end
         end
         EL_RD: begin
            state_in = EL_CHK;
         end
         EL_CHK: begin
            if (!sts.elem_match) begin
               cmd.entry_step = 1'b1;
               state_in       = LEN_RD;
            end else if (sts.elem_end) begin
               result_in = ST_FOUND;
               state_in  = RESULT;
            end else begin
               cmd.elem_step = 1'b1;
               state_in      = EL_RD;
            end
         end
         RESULT: begin
            if (!sts.rsp_busy) begin
               cmd.result_load = 1'b1;
               state_in        = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         result_ff <= ST_NOT_FOUND;
      end else begin
         state_ff  <= state_in;
         result_ff <= result_in;
      end
   end

   assign req_tready = (state_ff == IDLE);

endmodule

### rtl/sequence_dedup_cache.sv
// ----------------------------------------------------------------------------
// An element item passes through EXEC and back to IDLE; a store or too-long end item
// passes through EXEC and then waits in RESULT until the output register is free; a
// search end item walks the stored entries with LEN_RD and LEN_CHK per entry and
// EL_CHK per element compared, with EL_RD before each after the first. No reset pass:
// synchronous reset empties the table and the query position at once.
// ----------------------------------------------------------------------------
// sequence_dedup_cache: cache of descriptor sequences with identifiers
// Stores sequences arriving one descriptor per item and looks up queries
// against them, returning the identifier of the first equal entry.
// ----------------------------------------------------------------------------
module sequence_dedup_cache
   import sdc_pkg::*;
#(
   parameter int MAX_ENTRIES  = SDC_MAX_ENTRIES,
   parameter int MAX_CHILDREN = SDC_MAX_CHILDREN
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2*DESC_W-1:0] req_tdata,  // descriptor [15:0], seq_id [31:16]
   input  logic [OP_W-1:0]     req_tuser,  // operation [1:0]
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [ID_W-1:0]     rsp_tdata,  // found_id [15:0]
   output logic [STATUS_W-1:0] rsp_tuser   // status [2:0]
);

   cmd_type       cmd;
   dp_status_type sts;

   sdc_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sdc_datapath #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .MAX_CHILDREN (MAX_CHILDREN)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the sequence dedup cache
// Streams store, search and clear items into the cache under random gaps and
// output stalls, predicts each lookup status and identifier with its own copy
// of the tables, and compares every response in order. A short directed run
// covers the field extremes and the edge cases; a long random run follows,
// including a full table, an overlong sequence and a maximum-length entry.
// ----------------------------------------------------------------------------
module tb_top;
   import sdc_pkg::*;

   localparam int                ITEM_TARGET = 1850;
   localparam int                CYCLE_LIMIT = 1_000_000;
   localparam int                DRAIN_CYCLES = 100;
   localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;

   typedef struct packed {
      status_type      status;
      logic [ID_W-1:0] found_id;
   } lookup_result_type;

   // Shadow of the cache tables, and the responses they predict.
   class lookup_scoreboard;
      logic [ID_W-1:0]   entry_ids[SDC_MAX_ENTRIES];
      logic [8:0]        entry_lengths[SDC_MAX_ENTRIES];
      logic [DESC_W-1:0] entry_elements[SDC_MAX_ENTRIES*SDC_MAX_CHILDREN];
      logic [DESC_W-1:0] query_elements[SDC_MAX_CHILDREN];
      bit                elem_written[SDC_MAX_ENTRIES*SDC_MAX_CHILDREN];
      bit                query_written[SDC_MAX_CHILDREN];
      int unsigned       entry_count = 0;
      int unsigned       position = 0;
      bit                too_long = 0;
      lookup_result_type expected_lookups[$];
      int unsigned       failures = 0;
      int unsigned       responses_checked = 0;
      int unsigned       status_tally[5];

      function bit entry_matches(int unsigned e, int unsigned len);
         if (entry_lengths[e] != len) return 0;
         for (int j = 0; j < len; j++)
            if (entry_elements[e*SDC_MAX_CHILDREN + j] != query_elements[j]) return 0;
         return 1;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [DESC_W-1:0] desc,
                                 logic [ID_W-1:0] id, bit last);
         lookup_result_type r;
         int unsigned       len;
         if (op == OP_CLEAR) begin
            entry_count = 0;
            position = 0;
            too_long = 0;
            return;
         end
         if (op != OP_STORE && op != OP_SEARCH) return;
         if (position >= SDC_MAX_CHILDREN) begin
            too_long = 1;
         end else begin
            if (op == OP_STORE) begin
               if (entry_count < SDC_MAX_ENTRIES) begin
                  entry_elements[entry_count*SDC_MAX_CHILDREN + position] = desc;
                  elem_written[entry_count*SDC_MAX_CHILDREN + position] = 1;
               end
            end else begin
               query_elements[position] = desc;
               query_written[position] = 1;
            end
            position++;
         end
         if (!last) return;
         len = position;
         r.found_id = '0;
         if (too_long) begin
            r.status = ST_TOO_LONG;
         end else if (op == OP_STORE) begin
            if (entry_count < SDC_MAX_ENTRIES) begin
               entry_ids[entry_count] = id;
               entry_lengths[entry_count] = 9'(len);
               entry_count++;
               r.status = ST_STORED;
            end else begin
               r.status = ST_FULL;
            end
         end else begin
            r.status = ST_NOT_FOUND;
            for (int e = 0; e < entry_count; e++) begin
               if (entry_matches(e, len)) begin
                  r.status = ST_FOUND;
                  r.found_id = entry_ids[e];
                  break;
               end
            end
         end
         position = 0;
         too_long = 0;
         status_tally[r.status]++;
         expected_lookups.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [ID_W-1:0] found_id);
         lookup_result_type want;
         if (expected_lookups.size() == 0) begin
            failures++;
            $display("%0t: unexpected response, expected none, actual status %0d id %h",
                     $time, status, found_id);
            return;
         end
         want = expected_lookups.pop_front();
         responses_checked++;
         if (status !== want.status) begin
            failures++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
         end
         if (found_id !== want.found_id) begin
            failures++;
            $display("%0t: found_id mismatch, expected %h, actual %h",
                     $time, want.found_id, found_id);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [2*DESC_W-1:0] req_tdata = '0;  // descriptor [15:0], seq_id [31:16]
   logic [OP_W-1:0]     req_tuser = '0;  // operation [1:0]
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [ID_W-1:0]     rsp_tdata;       // found_id [15:0]
   logic [STATUS_W-1:0] rsp_tuser;       // status [2:0]

   lookup_scoreboard    board;
   op_type              seq_ops[$];
   logic [DESC_W-1:0]   seq_descs[$];
   int unsigned         items_sent = 0;
   int unsigned         items_ignored = 0;
   bit                  steady_phase = 0;
   int unsigned         hold_cycles = 0;
   int unsigned         ready_roll;
   int unsigned         cycles = 0;

   sequence_dedup_cache i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Output stalls: mostly short, a few long, with stretches of steady readiness.
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else begin
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 45) begin
            rsp_tready <= 1'b1;
            hold_cycles <= $urandom_range(0, 12);
         end else if (ready_roll < 55) begin
            rsp_tready <= 1'b1;
            hold_cycles <= $urandom_range(40, 120);
         end else if (ready_roll < 95) begin
            rsp_tready <= 1'b0;
            hold_cycles <= $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            hold_cycles <= $urandom_range(10, 60);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tuser, rsp_tdata);
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(logic [OP_W-1:0] op, logic [DESC_W-1:0] desc,
                            logic [ID_W-1:0] id, bit last);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {id, desc};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_request(op, desc, id, last);
      if (op == OP_UNUSED) items_ignored++;
      else items_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.expected_lookups.size() != 0) @(posedge clock);
   endtask

   // A mixed sequence must not make the cache compare or keep positions that
   // nothing has ever written.
   function automatic bit mixed_reads_defined();
      int unsigned n;
      n = seq_ops.size();
      if (n > SDC_MAX_CHILDREN) return 1;
      for (int i = 0; i < n; i++) begin
         if (seq_ops[n-1] == OP_SEARCH) begin
            if (seq_ops[i] != OP_SEARCH && !board.query_written[i]) return 0;
         end else if (board.entry_count < SDC_MAX_ENTRIES) begin
            if (seq_ops[i] != OP_STORE &&
                !board.elem_written[board.entry_count*SDC_MAX_CHILDREN + i]) return 0;
         end
      end
      return 1;
   endfunction

   // Flavours: random values, a small value pool, a copy of a stored entry,
   // a copy with one bit flipped, a copy one element shorter or longer.
   function automatic void build_sequence(op_type op, int unsigned len, int unsigned flavour);
      int unsigned e;
      int unsigned n;
      int unsigned p;
      seq_ops.delete();
      seq_descs.delete();
      n = len;
      if (flavour >= 2 && board.entry_count != 0) begin
         e = $urandom_range(0, board.entry_count - 1);
         if (board.entry_lengths[e] <= 24) begin
            for (int i = 0; i < board.entry_lengths[e]; i++)
               seq_descs.push_back(board.entry_elements[e*SDC_MAX_CHILDREN + i]);
            if (flavour == 3) begin
               p = $urandom_range(0, seq_descs.size() - 1);
               seq_descs[p] ^= 16'(1) << $urandom_range(0, 15);
            end else if (flavour == 4) begin
               if (seq_descs.size() > 1 && $urandom_range(0, 1) == 1) void'(seq_descs.pop_back());
               else seq_descs.push_back(16'($urandom));
            end
            n = seq_descs.size();
         end
      end
      while (seq_descs.size() < n)
         seq_descs.push_back(flavour == 1 ? 16'($urandom_range(0, 3)) : 16'($urandom));
      for (int i = 0; i < n; i++) seq_ops.push_back(op);
   endfunction

   function automatic void mix_operations();
      int unsigned n;
      n = seq_ops.size();
      for (int i = 0; i + 1 < n; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            if (seq_ops[i] == OP_STORE) seq_ops[i] = OP_SEARCH;
            else seq_ops[i] = OP_STORE;
         end
      end
      if (!mixed_reads_defined())
         for (int i = 0; i + 1 < n; i++) seq_ops[i] = seq_ops[n-1];
   endfunction

   task automatic send_sequence(logic [ID_W-1:0] id, bit complete);
      int unsigned n;
      bit          at_end;
      n = seq_descs.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 49) == 0)
            send_item(OP_UNUSED, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
         at_end = (i == n - 1);
         send_item(seq_ops[i], seq_descs[i], at_end ? id : 16'($urandom), at_end && complete);
      end
   endtask

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(1, 3);
      if (r < 85) return $urandom_range(4, 8);
      if (r < 98) return $urandom_range(9, 24);
      return $urandom_range(25, 64);
   endfunction

   task automatic random_scenario();
      int unsigned r;
      op_type      op;
      r = $urandom_range(0, 99);
      steady_phase = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) < 55) op = OP_SEARCH;
      else op = OP_STORE;
      if (r < 76) begin
         build_sequence(op, pick_length(), $urandom_range(0, 4));
         send_sequence(16'($urandom), 1'b1);
      end else if (r < 88) begin
         build_sequence(op, $urandom_range(2, 6), $urandom_range(0, 4));
         mix_operations();
         send_sequence(16'($urandom), 1'b1);
      end else if (r < 94) begin
         repeat ($urandom_range(1, 3))
            send_item(OP_UNUSED, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      end else if (r < 97) begin
         // A sequence broken off part-way; the clear restarts the position.
         build_sequence(op, $urandom_range(1, 5), $urandom_range(0, 1));
         send_sequence(16'($urandom), 1'b0);
         send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      end else begin
         send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic fill_and_overflow();
      wait_drained();
      while (board.entry_count < SDC_MAX_ENTRIES) begin
         if ($urandom_range(0, 9) == 0) build_sequence(OP_SEARCH, 1, $urandom_range(0, 2));
         else build_sequence(OP_STORE, 1, $urandom_range(0, 1));
         send_sequence(16'($urandom), 1'b1);
      end
      build_sequence(OP_STORE, 1, 0);
      send_sequence(16'($urandom), 1'b1);
      build_sequence(OP_STORE, 3, 0);
      send_sequence(16'($urandom), 1'b1);
      build_sequence(OP_SEARCH, 1, 2);
      send_sequence(16'($urandom), 1'b1);
      // Overlong while full: the length status wins over the full one.
      build_sequence(OP_STORE, SDC_MAX_CHILDREN + 1, 0);
      send_sequence(16'($urandom), 1'b1);
      send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 1'b0);
      wait_drained();
   endtask

   initial begin
      bit fill_done;
      bit boundary_done;
      fill_done = 0;
      boundary_done = 0;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_SEARCH, 16'h0000, 16'h0000, 1'b1);
      send_item(OP_STORE,  16'h0000, 16'h0000, 1'b1);
      send_item(OP_STORE,  16'hFFFF, 16'hFFFF, 1'b1);
      send_item(OP_SEARCH, 16'hFFFF, 16'h0000, 1'b1);
      send_item(OP_SEARCH, 16'h0000, 16'hFFFF, 1'b1);
      send_item(OP_STORE,  16'h1234, 16'h0000, 1'b0);
      send_item(OP_STORE,  16'h5678, 16'hFFFF, 1'b0);
      send_item(OP_STORE,  16'h9ABC, 16'hA5A5, 1'b1);
      // A prefix of a stored entry must not match it.
      send_item(OP_SEARCH, 16'h1234, 16'h0000, 1'b0);
      send_item(OP_SEARCH, 16'h5678, 16'h0000, 1'b1);
      // Duplicate entry: the search must return the earlier identifier.
      send_item(OP_STORE,  16'hFFFF, 16'h1111, 1'b1);
      send_item(OP_SEARCH, 16'hFFFF, 16'h0000, 1'b1);
      send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
      // Mixed sequences share one position counter between the two buffers.
      send_item(OP_STORE,  16'hC3C3, 16'h0000, 1'b0);
      send_item(OP_SEARCH, 16'h0F0F, 16'h0000, 1'b1);
      send_item(OP_SEARCH, 16'h1111, 16'h0000, 1'b0);
      send_item(OP_STORE,  16'h3C3C, 16'h7E7E, 1'b1);
      send_item(OP_SEARCH, 16'hC3C3, 16'h0000, 1'b0);
      send_item(OP_SEARCH, 16'h3C3C, 16'h0000, 1'b1);
      send_item(OP_SEARCH, 16'hAAAA, 16'h0000, 1'b0);
      send_item(OP_CLEAR,  16'h5555, 16'hFFFF, 1'b1);
      send_item(OP_SEARCH, 16'hFFFF, 16'h0000, 1'b1);
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         if (!fill_done && items_sent > 500) begin
            fill_and_overflow();
            fill_done = 1;
         end else if (!boundary_done && items_sent > 1150) begin
            // Longest sequence that still fits in one entry.
            build_sequence(OP_STORE, SDC_MAX_CHILDREN, 0);
            send_sequence(16'($urandom), 1'b1);
            boundary_done = 1;
         end else begin
            random_scenario();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items (%0d more ignored); checked %0d responses.",
               items_sent, items_ignored, board.responses_checked);
      $display("Statuses: %0d found, %0d not found, %0d stored, %0d full, %0d too long.",
               board.status_tally[ST_FOUND], board.status_tally[ST_NOT_FOUND],
               board.status_tally[ST_STORED], board.status_tally[ST_FULL],
               board.status_tally[ST_TOO_LONG]);
      if (board.failures == 0 && board.expected_lookups.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
